// ===== hw/rtl/mamt_pkg.sv =====
// ----------------------------------------------------------------------------
// mamt_pkg: shared types and constants for the matrix add/multiply/transpose unit
// Sizes, request and operation codes, and the item structs of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

package mamt_pkg;

  localparam int MaxDim    = 8;
  localparam int ElemWidth = 16;
  localparam int IdxWidth  = $clog2(MaxDim);
  localparam int AddrWidth = 2 * IdxWidth;
  localparam int Depth     = MaxDim * MaxDim;
  localparam int DimWidth  = 4;
  localparam int ValWidth  = 40;
  localparam int ProdWidth = 2 * ElemWidth;
  localparam int CfgIdxWidth = 2;

  typedef enum logic [1:0] {
    ReqLoadA = 2'd0,
    ReqLoadB = 2'd1,
    ReqRun   = 2'd2,
    ReqNone  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    OpAdd    = 2'd0,
    OpMul    = 2'd1,
    OpTransA = 2'd2,
    OpTransB = 2'd3
  } op_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgRowsA = 2'd0,
    CfgColsA = 2'd1,
    CfgRowsB = 2'd2,
    CfgColsB = 2'd3
  } cfg_e;

  typedef struct packed {
    req_e                        req_type;
    logic [2:0]                  elem_row;
    logic [2:0]                  elem_col;
    logic signed [15:0]          elem_value;
    op_e                         operation;
  } in_item_t;

  typedef struct packed {
    logic [2:0]                  out_row;
    logic [2:0]                  out_col;
    logic signed [ValWidth-1:0]  out_value;
    logic                        status;
    logic                        last;
  } out_item_t;

  // Flags that travel with one read beat down the pipeline.
  typedef struct packed {
    logic                        vld;
    logic                        first;
    logic                        last_k;
    logic                        last_el;
    logic [IdxWidth-1:0]         row;
    logic [IdxWidth-1:0]         col;
  } beat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/matrix_add_multiply_transpose_unit.sv =====
// ----------------------------------------------------------------------------
// matrix_add_multiply_transpose_unit: integer matrix add, multiply, transpose
// Two element memories (A, B), a read sequencer, one shared multiplier and an
// accumulator that emits result elements in row-major order.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                     | payload
//  ----------+-----------+-------------------------------+----------------------
//  request   | in        | start_i && !busy_o            | in_item_i
//  result    | out       | res_valid_o (one cycle)       | res_o
//  config    | in        | cfg_valid_i && cfg_ready_o    | cfg_index_i, cfg_data_i
//
// A run issues one memory read per cycle: one per element for add and transpose,
// cols_a per element for multiply (up to 8, 512 for 8x8). Each result passes the
// read data, product or sum, and output registers after its last read; busy_o
// holds until the pipeline drains. A shape error gives its result the cycle after
// start. Reset clears control and sets the shape registers to 1; memory is
// undefined until loaded. The receiver cannot stall; cfg_ready_o is high.
`default_nettype none

module matrix_add_multiply_transpose_unit (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start_i,
  output logic                                      busy_o,
  input  wire mamt_pkg::in_item_t                   in_item_i,
  output logic                                      res_valid_o,
  output mamt_pkg::out_item_t                       res_o,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [mamt_pkg::CfgIdxWidth-1:0]     cfg_index_i,
  input  wire logic [mamt_pkg::DimWidth-1:0]        cfg_data_i
);

  localparam int IW = mamt_pkg::IdxWidth;
  localparam int EW = mamt_pkg::ElemWidth;
  localparam int VW = mamt_pkg::ValWidth;

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StRun  = 2'b10
  } state_e;

  // Clamp a dimension register to 1..MaxDim and return its highest index.
  function automatic logic [IW-1:0] max_idx(input logic [mamt_pkg::DimWidth-1:0] r);
    logic [IW-1:0] res;
    if (r == '0) begin
      res = '0;
    end else if (r > mamt_pkg::DimWidth'(mamt_pkg::MaxDim)) begin
      res = IW'(mamt_pkg::MaxDim - 1);
    end else begin
      res = IW'(r - 1'b1);
    end
    return res;
  endfunction

  // Shape registers
  logic [mamt_pkg::DimWidth-1:0] rows_a_q, cols_a_q, rows_b_q, cols_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q <= mamt_pkg::DimWidth'(1);
      cols_a_q <= mamt_pkg::DimWidth'(1);
      rows_b_q <= mamt_pkg::DimWidth'(1);
      cols_b_q <= mamt_pkg::DimWidth'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (mamt_pkg::cfg_e'(cfg_index_i))
        mamt_pkg::CfgRowsA: rows_a_q <= cfg_data_i;
        mamt_pkg::CfgColsA: cols_a_q <= cfg_data_i;
        mamt_pkg::CfgRowsB: rows_b_q <= cfg_data_i;
        mamt_pkg::CfgColsB: cols_b_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  logic [IW-1:0] ra, ca, rb, cb;
  assign ra = max_idx(rows_a_q);
  assign ca = max_idx(cols_a_q);
  assign rb = max_idx(rows_b_q);
  assign cb = max_idx(cols_b_q);

  // Request decode
  state_e state_q, state_d;
  logic   accept, run_go, shape_err;

  assign accept = start_i && !busy_o;

  always_comb begin
    shape_err = 1'b0;
    case (in_item_i.operation)
      mamt_pkg::OpAdd: shape_err = (ra != rb) || (ca != cb);
      mamt_pkg::OpMul: shape_err = (ca != rb);
      default:         shape_err = 1'b0;
    endcase
  end

  assign run_go = accept && (in_item_i.req_type == mamt_pkg::ReqRun);

  // Element memories
  logic signed [EW-1:0] mem_a [mamt_pkg::Depth];
  logic signed [EW-1:0] mem_b [mamt_pkg::Depth];
  logic signed [EW-1:0] rd_a_q, rd_b_q;
  logic [mamt_pkg::AddrWidth-1:0] wr_addr, rd_addr_a, rd_addr_b;
  logic rd_en;

  assign wr_addr = {in_item_i.elem_row, in_item_i.elem_col};

  // Loads are only taken while no run is reading, so no forwarding is needed.
  always_ff @(posedge clk_i) begin
    if (accept && in_item_i.req_type == mamt_pkg::ReqLoadA) begin
      mem_a[wr_addr] <= in_item_i.elem_value[EW-1:0];
    end
    if (rd_en) begin
      rd_a_q <= mem_a[rd_addr_a];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_item_i.req_type == mamt_pkg::ReqLoadB) begin
      mem_b[wr_addr] <= in_item_i.elem_value[EW-1:0];
    end
    if (rd_en) begin
      rd_b_q <= mem_b[rd_addr_b];
    end
  end

  // Read sequencer
  mamt_pkg::op_e op_q;
  logic [IW-1:0] lim_i_q, lim_j_q, lim_k_q;
  logic [IW-1:0] i_q, j_q, k_q, i_d, j_d, k_d;
  mamt_pkg::beat_t beat0;

  always_comb begin
    state_d = state_q;
    i_d = i_q;
    j_d = j_q;
    k_d = k_q;
    case (state_q)
      StIdle: begin
        if (run_go && !shape_err) begin
          state_d = StRun;
          i_d = '0;
          j_d = '0;
          k_d = '0;
        end
      end
      StRun: begin
        if (k_q != lim_k_q) begin
          k_d = k_q + 1'b1;
        end else begin
          k_d = '0;
          if (j_q != lim_j_q) begin
            j_d = j_q + 1'b1;
          end else begin
            j_d = '0;
            if (i_q != lim_i_q) begin
              i_d = i_q + 1'b1;
            end else begin
              state_d = StIdle;
            end
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign rd_en = (state_q == StRun);

  always_comb begin
    case (op_q)
      mamt_pkg::OpAdd: begin
        rd_addr_a = {i_q, j_q};
        rd_addr_b = {i_q, j_q};
      end
      mamt_pkg::OpMul: begin
        rd_addr_a = {i_q, k_q};
        rd_addr_b = {k_q, j_q};
      end
      default: begin
        rd_addr_a = {j_q, i_q};
        rd_addr_b = {j_q, i_q};
      end
    endcase
  end

  assign beat0.vld     = rd_en;
  assign beat0.first   = (k_q == '0);
  assign beat0.last_k  = (k_q == lim_k_q);
  assign beat0.last_el = (k_q == lim_k_q) && (j_q == lim_j_q) && (i_q == lim_i_q);
  assign beat0.row     = i_q;
  assign beat0.col     = j_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d;
    j_q <= j_d;
    k_q <= k_d;
    if (run_go && !shape_err) begin
      op_q <= in_item_i.operation;
      case (in_item_i.operation)
        mamt_pkg::OpAdd: begin
          lim_i_q <= ra;
          lim_j_q <= ca;
          lim_k_q <= '0;
        end
        mamt_pkg::OpMul: begin
          lim_i_q <= ra;
          lim_j_q <= cb;
          lim_k_q <= ca;
        end
        mamt_pkg::OpTransA: begin
          lim_i_q <= ca;
          lim_j_q <= ra;
          lim_k_q <= '0;
        end
        default: begin
          lim_i_q <= cb;
          lim_j_q <= rb;
          lim_k_q <= '0;
        end
      endcase
    end
  end

  // Pipeline: read data -> product, sum or element -> accumulate and emit
  mamt_pkg::beat_t beat1_q, beat2_q;
  logic signed [VW-1:0] val2_q, val2_d, acc_q, acc_d;
  logic signed [mamt_pkg::ProdWidth-1:0] prod;
  logic signed [EW:0] sum;

  assign prod = mamt_pkg::ProdWidth'(rd_a_q) * mamt_pkg::ProdWidth'(rd_b_q);
  assign sum  = (EW+1)'(rd_a_q) + (EW+1)'(rd_b_q);

  always_comb begin
    case (op_q)
      mamt_pkg::OpAdd:    val2_d = VW'(sum);
      mamt_pkg::OpMul:    val2_d = VW'(prod);
      mamt_pkg::OpTransA: val2_d = VW'(rd_a_q);
      default:            val2_d = VW'(rd_b_q);
    endcase
  end

  assign acc_d = beat2_q.first ? val2_q : acc_q + val2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat1_q     <= '0;
      beat2_q     <= '0;
      res_valid_o <= 1'b0;
    end else begin
      beat1_q     <= beat0;
      beat2_q     <= beat1_q;
      res_valid_o <= (beat2_q.vld && beat2_q.last_k) || (run_go && shape_err);
    end
  end

  always_ff @(posedge clk_i) begin
    val2_q <= val2_d;
    if (beat2_q.vld) begin
      acc_q <= acc_d;
    end
    // Error result replaces the element path; the two never coincide.
    if (run_go && shape_err) begin
      res_o <= '{out_row: '0, out_col: '0, out_value: '0, status: 1'b1, last: 1'b1};
    end else begin
      res_o <= '{out_row: 3'(beat2_q.row), out_col: 3'(beat2_q.col), out_value: acc_d,
                 status: 1'b0, last: beat2_q.last_el};
    end
  end

  assign busy_o = (state_q == StRun) || beat1_q.vld || beat2_q.vld;

endmodule

`default_nettype wire
